@@ rtl/rtp_pkg.sv @@
package rtp_pkg;

    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int REG_W    = 6;
    localparam int TS_W     = 63;
    localparam int CNT_OUT_W = 32;

    localparam int S_DATA_W = 72;   // region, timestamp, zero fill
    localparam int M_DATA_W = 360;  // region_out .. second_smallest, zero fill
    localparam int M_FILL_W = M_DATA_W - (REG_W + 5 * TS_W + CNT_OUT_W);

    localparam logic [TS_W-1:0] TS_MAX        = {TS_W{1'b1}};
    localparam logic [TS_W-1:0] MAX_TOP_INIT  = TS_W'(1);
    localparam logic [TS_W-1:0] MAX_NEXT_INIT = '0;
    localparam logic [TS_W-1:0] MIN_LOW_INIT  = TS_MAX - TS_W'(1);
    localparam logic [TS_W-1:0] MIN_NEXT_INIT = TS_MAX;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE          = 2'd0,
        ST_BEGIN_IGNORED = 2'd1,
        ST_END_IGNORED   = 2'd2,
        ST_READ          = 2'd3
    } status_t;

    typedef struct packed {
        logic clear;   // write reset row at the sweep address
        logic load;    // capture request, read its row
        logic calc;    // register the duration
        logic commit;  // write row back, load result register
    } rtp_cmd_t;

    typedef struct packed {
        logic out_free;
    } rtp_stat_t;

endpackage

@@ rtl/rtp_ctrl.sv @@
module rtp_ctrl
    import rtp_pkg::*;
#(
    parameter int REGIONS = 64,
    parameter int ROW_W   = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rtp_stat_t        dp_stat,
    output rtp_cmd_t         cmd,
    output logic [ROW_W-1:0] clr_addr
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_COMMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                cnt_next = cnt_reg + ROW_W'(1);
                if (cnt_reg == ROW_W'(REGIONS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the new result
                if (dp_stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.load   = s_tready && s_tvalid;
    assign cmd.calc   = (state_reg == S_CALC);
    assign cmd.commit = (state_reg == S_COMMIT) && dp_stat.out_free;
    assign clr_addr   = cnt_reg;

endmodule

@@ rtl/rtp_datapath.sv @@
module rtp_datapath
    import rtp_pkg::*;
#(
    parameter int REGIONS    = 64,
    parameter int CALL_WIDTH = 32,
    parameter int ROW_W      = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtp_cmd_t            cmd,
    input  logic [ROW_W-1:0]    clr_addr,
    output rtp_stat_t           dp_stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]   m_tuser
);

    localparam int CALL_EXT_W = (CALL_WIDTH > CNT_OUT_W) ? CALL_WIDTH : CNT_OUT_W;
    localparam int MAP_DEPTH  = 2 ** REG_W;

    // statistics table, one row per region
    logic                  run_mem   [REGIONS];
    logic [TS_W-1:0]       start_mem [REGIONS];
    logic [TS_W-1:0]       sum_mem   [REGIONS];
    logic [CALL_WIDTH-1:0] calls_mem [REGIONS];
    logic [TS_W-1:0]       maxt_mem  [REGIONS];
    logic [TS_W-1:0]       maxn_mem  [REGIONS];
    logic [TS_W-1:0]       minl_mem  [REGIONS];
    logic [TS_W-1:0]       minn_mem  [REGIONS];

    logic [ROW_W-1:0]      row_map [MAP_DEPTH];
    logic [ROW_W-1:0]      load_row;
    logic [REG_W-1:0]      s_region;

    op_t                   op_reg;
    logic [REG_W-1:0]      region_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [TS_W-1:0]       ts_reg;
    logic [TS_W-1:0]       dur_reg;

    logic                  rd_run_reg;
    logic [TS_W-1:0]       rd_start_reg, rd_sum_reg;
    logic [CALL_WIDTH-1:0] rd_calls_reg;
    logic [TS_W-1:0]       rd_maxt_reg, rd_maxn_reg, rd_minl_reg, rd_minn_reg;

    logic                  run_next;
    logic [TS_W-1:0]       start_next, sum_next;
    logic [CALL_WIDTH-1:0] calls_next;
    logic [TS_W-1:0]       maxt_next, maxn_next, minl_next, minn_next;
    status_t               status_next;
    logic [TS_W:0]         sum_wide;
    logic [CALL_EXT_W-1:0] calls_ext;

    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [STAT_W-1:0]     m_tuser_reg;

    // fold indexes beyond the table onto a row
    for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_map
        assign row_map[g] = ROW_W'(g % REGIONS);
    end

    assign s_region = s_tdata[REG_W-1:0];
    assign load_row = row_map[s_region];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= op_t'(s_tuser);
            region_reg   <= s_region;
            row_reg      <= load_row;
            ts_reg       <= s_tdata[REG_W +: TS_W];
            rd_run_reg   <= run_mem[load_row];
            rd_start_reg <= start_mem[load_row];
            rd_sum_reg   <= sum_mem[load_row];
            rd_calls_reg <= calls_mem[load_row];
            rd_maxt_reg  <= maxt_mem[load_row];
            rd_maxn_reg  <= maxn_mem[load_row];
            rd_minl_reg  <= minl_mem[load_row];
            rd_minn_reg  <= minn_mem[load_row];
        end
        if (cmd.calc) begin
            dur_reg <= ts_reg - rd_start_reg;
        end
    end

    always_comb begin
        run_next    = rd_run_reg;
        start_next  = rd_start_reg;
        sum_next    = rd_sum_reg;
        calls_next  = rd_calls_reg;
        maxt_next   = rd_maxt_reg;
        maxn_next   = rd_maxn_reg;
        minl_next   = rd_minl_reg;
        minn_next   = rd_minn_reg;
        sum_wide    = {1'b0, rd_sum_reg} + {1'b0, dur_reg};
        case (op_reg)
            OP_BEGIN: begin
                if (rd_run_reg) begin
                    status_next = ST_BEGIN_IGNORED;
                end else begin
                    start_next  = ts_reg;
                    run_next    = 1'b1;
                    status_next = ST_DONE;
                end
            end
            OP_END: begin
                if (rd_run_reg) begin
                    run_next = 1'b0;
                    sum_next = sum_wide[TS_W] ? TS_MAX : sum_wide[TS_W-1:0];
                    if (rd_calls_reg != {CALL_WIDTH{1'b1}}) begin
                        calls_next = rd_calls_reg + CALL_WIDTH'(1);
                    end
                    if (dur_reg > rd_maxt_reg) begin
                        maxn_next = rd_maxt_reg;
                        maxt_next = dur_reg;
                    end else if (dur_reg > rd_maxn_reg) begin
                        maxn_next = dur_reg;
                    end
                    if (dur_reg < rd_minl_reg) begin
                        minn_next = rd_minl_reg;
                        minl_next = dur_reg;
                    end else if (dur_reg < rd_minn_reg) begin
                        minn_next = dur_reg;
                    end
                    status_next = ST_DONE;
                end else begin
                    status_next = ST_END_IGNORED;
                end
            end
            default: begin
                status_next = ST_READ;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            run_mem[clr_addr]   <= 1'b0;
            start_mem[clr_addr] <= '0;
            sum_mem[clr_addr]   <= '0;
            calls_mem[clr_addr] <= '0;
            maxt_mem[clr_addr]  <= MAX_TOP_INIT;
            maxn_mem[clr_addr]  <= MAX_NEXT_INIT;
            minl_mem[clr_addr]  <= MIN_LOW_INIT;
            minn_mem[clr_addr]  <= MIN_NEXT_INIT;
        end else if (cmd.commit) begin
            run_mem[row_reg]   <= run_next;
            start_mem[row_reg] <= start_next;
            sum_mem[row_reg]   <= sum_next;
            calls_mem[row_reg] <= calls_next;
            maxt_mem[row_reg]  <= maxt_next;
            maxn_mem[row_reg]  <= maxn_next;
            minl_mem[row_reg]  <= minl_next;
            minn_mem[row_reg]  <= minn_next;
        end
    end

    assign calls_ext = CALL_EXT_W'(calls_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tuser_reg <= status_next;
            m_tdata_reg <= {{M_FILL_W{1'b0}}, minn_next, minl_next, maxn_next, maxt_next,
                            calls_ext[CNT_OUT_W-1:0], sum_next, region_reg};
        end
    end

    assign dp_stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;
    assign m_tuser          = m_tuser_reg;

endmodule

@@ rtl/region_timing_profiler.sv @@
// Channel   Ports                    tuser              tdata (from bit 0)
// s_ (in)   s_tvalid/tready/tdata    operation [1:0]    region [5:0], timestamp [68:6]
// m_ (out)  m_tvalid/tready/tdata    status [1:0]       region_out [5:0], total_time [68:6],
//                                                        call_count [100:69], largest [163:101],
//                                                        second_largest [226:164],
//                                                        smallest [289:227],
//                                                        second_smallest [352:290]
//
// A request goes through table row read, duration subtract, then update and write back.
// The table has one read/write port, so one request is in flight at a time: a new request
// is accepted only once the previous one has been written back.
// After reset a clearing pass writes one row per cycle over all REGIONS rows with s_tready low.
// A stalled result holds the write-back step of the next request until m_tready frees the
// result register.
module region_timing_profiler
    import rtp_pkg::*;
#(
    parameter int REGIONS    = 64,
    parameter int CALL_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // region, timestamp, zero fill
    input  logic [OP_W-1:0]     s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // region_out, total_time, call_count, largest,
                                           // second_largest, smallest, second_smallest, fill
    output logic [STAT_W-1:0]   m_tuser    // status
);

    localparam int ROW_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    rtp_cmd_t         cmd;
    rtp_stat_t        dp_stat;
    logic [ROW_W-1:0] clr_addr;

    rtp_ctrl #(
        .REGIONS (REGIONS),
        .ROW_W   (ROW_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd),
        .clr_addr (clr_addr)
    );

    rtp_datapath #(
        .REGIONS    (REGIONS),
        .CALL_WIDTH (CALL_WIDTH),
        .ROW_W      (ROW_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .clr_addr (clr_addr),
        .dp_stat  (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result appeared without a write-back");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("write-back overwrote a pending result");

    a_load_then_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cmd.calc && !s_tready))
        else $error("accepted request did not advance to duration step");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_tready)
        else $error("request accepted during clearing pass");

endmodule
